// ===== rtl/core/envelope_peak_limiter_macros.svh =====
// Assertion macros for the limiter control module.
// Each macro expects clk and rst_n in scope.
`ifndef ENVELOPE_PEAK_LIMITER_MACROS_SVH
`define ENVELOPE_PEAK_LIMITER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define ELP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("limiter: same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define ELP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("limiter: next-cycle check failed");

`endif

// ===== rtl/core/elp_pkg.sv =====
`default_nettype none

package elp_pkg;

    // Fixed field widths
    localparam int CEIL_W     = 24;
    localparam int COEF_W     = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;

    // Register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ATTACK  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE = 2'd2;

    // Register reset values
    localparam logic [CEIL_W-1:0] CEILING_RESET = 24'd8292560;
    localparam logic [COEF_W-1:0] ATTACK_RESET  = 16'd64184;
    localparam logic [COEF_W-1:0] RELEASE_RESET = 16'd65522;

    // Half an LSB of the Q0.16 product, for round half up
    localparam logic [COEF_W-1:0] ROUND_HALF = 16'h8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_UPD,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic env_step;
        logic upd_step;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/envelope_peak_limiter.sv =====
// A request is accepted in idle, then passes the envelope, update, multiply, prepare and divide
// states; the result is loaded into the output register once that register is free. The
// restoring divider yields one quotient bit per cycle, and a new request waits for that load.
// A finished result sits in the output register while the next request is accepted.
// Reset: envelopes clear to zero, registers take their defaults, output register empties.
`default_nettype none

module envelope_peak_limiter #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int CHANNELS     = 2
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata, // sample_in
    input  wire logic [0:0]                           s_axis_tuser, // channel
    // Output stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata, // sample_out
    output logic [1:0]                                m_axis_tuser, // channel_out, limiting
    // Configuration
    input  wire logic                                 cfg_we,
    input  wire logic [elp_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [elp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam int DATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;

    logic [elp_pkg::CEIL_W-1:0] ceiling_reg;
    logic [elp_pkg::COEF_W-1:0] attack_reg;
    logic [elp_pkg::COEF_W-1:0] release_reg;

    elp_pkg::cmd_t              cmd;
    elp_pkg::status_t           status;
    logic                       out_channel;
    logic [SAMPLE_WIDTH-1:0]    out_sample;
    logic                       out_limiting;

    // Write configuration registers; ignore unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceiling_reg <= elp_pkg::CEILING_RESET;
            attack_reg  <= elp_pkg::ATTACK_RESET;
            release_reg <= elp_pkg::RELEASE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                elp_pkg::CFG_CEILING: ceiling_reg <= cfg_wdata[elp_pkg::CEIL_W-1:0];
                elp_pkg::CFG_ATTACK:  attack_reg  <= cfg_wdata[elp_pkg::COEF_W-1:0];
                elp_pkg::CFG_RELEASE: release_reg <= cfg_wdata[elp_pkg::COEF_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    elp_ctrl #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready),
        .cmd     (cmd),
        .status  (status)
    );

    elp_dp #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .CHANNELS    (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .ceiling     (ceiling_reg),
        .attack      (attack_reg),
        .release_c   (release_reg),
        .in_channel  (s_axis_tuser[0]),
        .in_sample   (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_channel (out_channel),
        .out_sample  (out_sample),
        .out_limiting(out_limiting)
    );

    // Pack the result; pad the data to whole bytes with zeros
    assign m_axis_tdata = DATA_W'(out_sample);
    assign m_axis_tuser = {out_limiting, out_channel};

endmodule

`default_nettype wire

// ===== rtl/core/elp_dp.sv =====
`default_nettype none

module elp_dp #(
    parameter int SAMPLE_WIDTH = 24,
    parameter int CHANNELS     = 2
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire elp_pkg::cmd_t                   cmd,
    output elp_pkg::status_t                     status,
    input  wire logic [elp_pkg::CEIL_W-1:0]      ceiling,
    input  wire logic [elp_pkg::COEF_W-1:0]      attack,
    input  wire logic [elp_pkg::COEF_W-1:0]      release_c,
    input  wire logic                            in_channel,
    input  wire logic [SAMPLE_WIDTH-1:0]         in_sample,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 out_channel,
    output logic [SAMPLE_WIDTH-1:0]              out_sample,
    output logic                                 out_limiting
);

    localparam int W          = SAMPLE_WIDTH;
    localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENV_PROD_W = W + elp_pkg::COEF_W + 2;
    localparam int MUL_W      = W + elp_pkg::CEIL_W;
    localparam int NUM_W      = 2 * W - 1;
    localparam int CMP_W      = (W > elp_pkg::CEIL_W) ? W : elp_pkg::CEIL_W;

    // Request registers
    logic                         ch_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic                         neg_reg;
    logic [W-1:0]                 mag_reg;
    logic [W-1:0]                 samp_reg;

    // Envelope state, one entry per channel
    logic [W-1:0]                 env_mem [CHANNELS];

    // Working registers
    logic signed [ENV_PROD_W-1:0] prod_reg;
    logic [W-1:0]                 env_new_reg;
    logic                         lim_reg;
    logic [NUM_W-1:0]             num_reg;
    logic [W-1:0]                 rem_reg;
    logic [W-2:0]                 quo_reg;

    // Output register
    logic                         out_valid_reg;
    logic                         out_ch_reg;
    logic [W-1:0]                 out_data_reg;
    logic                         out_lim_reg;

    logic [IDX_W-1:0]             idx_load;
    logic [W-1:0]                 mag_load;
    logic [W-1:0]                 env_cur;
    logic signed [W:0]            env_diff;
    logic [elp_pkg::COEF_W-1:0]   coef;
    logic signed [ENV_PROD_W-1:0] prod_next;
    logic signed [ENV_PROD_W-1:0] env_sum;
    logic [W-1:0]                 env_upd;
    logic [MUL_W-1:0]             num_wide;
    logic                         lim_next;
    logic [W:0]                   trial;
    logic [W:0]                   trial_sub;
    logic                         trial_ge;
    logic [W-1:0]                 quo_ext;
    logic [W-1:0]                 result;

    // Fold the channel onto the state index and take the magnitude
    assign idx_load = (CHANNELS == 1) ? '0 : IDX_W'(in_channel);
    assign mag_load = in_sample[W-1] ? (W'(0) - in_sample) : in_sample;

    // Pick the coefficient from the sign of env - mag and scale the difference
    assign env_cur   = env_mem[idx_reg];
    assign env_diff  = $signed({1'b0, env_cur}) - $signed({1'b0, mag_reg});
    assign coef      = env_diff[W] ? attack : release_c;
    assign prod_next = ENV_PROD_W'(env_diff) * ENV_PROD_W'($signed({1'b0, coef}));

    // env' = (mag * 2^16 + c * (env - mag) + half) >> 16
    assign env_sum = $signed({2'b00, mag_reg, elp_pkg::COEF_W'(0)}) + prod_reg
                   + $signed({{(W + 2){1'b0}}, elp_pkg::ROUND_HALF});
    assign env_upd = env_sum[W + elp_pkg::COEF_W - 1 : elp_pkg::COEF_W];

    // Gain numerator and ceiling compare
    assign num_wide = MUL_W'(mag_reg) * MUL_W'(ceiling);
    assign lim_next = CMP_W'(env_new_reg) > CMP_W'(ceiling);

    // One restoring division step
    assign trial     = {rem_reg, quo_reg[W-2]};
    assign trial_sub = trial - {1'b0, env_new_reg};
    assign trial_ge  = trial >= {1'b0, env_new_reg};

    // Apply the sign to the quotient or pass the sample
    assign quo_ext = {1'b0, quo_reg};
    assign result  = lim_reg ? (neg_reg ? (W'(0) - quo_ext) : quo_ext) : samp_reg;

    // Hold the envelopes; reset clears them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                env_mem[i] <= '0;
            end
        end
        else if (cmd.upd_step)
        begin
            env_mem[idx_reg] <= env_upd;
        end
    end

    // Advance the working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ch_reg   <= in_channel;
            idx_reg  <= idx_load;
            neg_reg  <= in_sample[W-1];
            mag_reg  <= mag_load;
            samp_reg <= in_sample;
        end
        if (cmd.env_step)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.upd_step)
        begin
            env_new_reg <= env_upd;
        end
        if (cmd.mul_step)
        begin
            num_reg <= NUM_W'(num_wide);
            lim_reg <= lim_next;
        end
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[NUM_W-1 -: W];
            quo_reg <= num_reg[W-2:0];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= trial_ge ? trial_sub[W-1:0] : trial[W-1:0];
            quo_reg <= {quo_reg[W-3:0], trial_ge};
        end
        if (cmd.out_load)
        begin
            out_ch_reg   <= ch_reg;
            out_data_reg <= result;
            out_lim_reg  <= lim_reg;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_channel     = out_ch_reg;
    assign out_sample      = out_data_reg;
    assign out_limiting    = out_lim_reg;

endmodule

`default_nettype wire

// ===== rtl/core/elp_ctrl.sv =====
`default_nettype none
`include "envelope_peak_limiter_macros.svh"

module elp_ctrl #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output elp_pkg::cmd_t            cmd,
    input  wire elp_pkg::status_t    status
);

    localparam int STEPS = SAMPLE_WIDTH - 1;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(STEPS - 1);

    elp_pkg::state_t  state_reg;
    elp_pkg::state_t  state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elp_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Sequence one request through envelope, gain, division and the output load
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            elp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = elp_pkg::ST_ENV;
                end
            end
            elp_pkg::ST_ENV:
            begin
                cmd.env_step = 1'b1;
                state_next   = elp_pkg::ST_UPD;
            end
            elp_pkg::ST_UPD:
            begin
                cmd.upd_step = 1'b1;
                state_next   = elp_pkg::ST_MUL;
            end
            elp_pkg::ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next   = elp_pkg::ST_PREP;
            end
            elp_pkg::ST_PREP:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = elp_pkg::ST_DIV;
            end
            elp_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = elp_pkg::ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            elp_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = elp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = elp_pkg::ST_IDLE;
            end
        endcase
    end

    `ELP_ASSERT_NEXT(a_accept_starts_env, in_valid && in_ready, state_reg == elp_pkg::ST_ENV)
    `ELP_ASSERT_NEXT(a_prep_clears_count, state_reg == elp_pkg::ST_PREP, state_reg == elp_pkg::ST_DIV && cnt_reg == '0)
    `ELP_ASSERT_SAME(a_div_count_range, state_reg == elp_pkg::ST_DIV, cnt_reg <= LAST_CNT)
    `ELP_ASSERT_SAME(a_load_needs_room, cmd.out_load, status.out_free)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam int     SW          = 24;
    localparam int     CHANNELS    = 2;
    localparam int     TDATA_W     = ((SW + 7) / 8) * 8;
    localparam int     CEIL_W      = elp_pkg::CEIL_W;
    localparam int     COEF_W      = elp_pkg::COEF_W;
    localparam int     CFG_ADDR_W  = elp_pkg::CFG_ADDR_W;
    localparam int     CFG_DATA_W  = elp_pkg::CFG_DATA_W;
    localparam longint SAMPLE_MAX  = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN  = -(longint'(1) <<< (SW - 1));
    localparam int     HOLD_CYCLES = 300;
    localparam int     IDLE_LIMIT  = 3000;
    localparam int     SETTLE      = 40;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;   // sample_in
    logic [0:0]         s_axis_tuser;   // channel
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;   // sample_out
    logic [1:0]         m_axis_tuser;   // channel_out, limiting
    logic               cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // One limited sample as it leaves the block
    typedef struct {
        logic          channel;
        logic [SW-1:0] value;
        logic          limiting;
    } limiter_result_t;

    // Envelope tracker and gain computer, plus the queue of pending results
    class limiter_scoreboard;
        logic [CEIL_W-1:0] ceiling;
        logic [COEF_W-1:0] attack_c;
        logic [COEF_W-1:0] release_c;
        logic [SW-1:0]     envelope [CHANNELS];
        limiter_result_t   expected_q [$];
        int                errors;
        int                checked;
        int                limited;

        function new();
            ceiling   = elp_pkg::CEILING_RESET;
            attack_c  = elp_pkg::ATTACK_RESET;
            release_c = elp_pkg::RELEASE_RESET;
            foreach (envelope[i])
                envelope[i] = '0;
            errors  = 0;
            checked = 0;
            limited = 0;
        endfunction

        function void set_regs(input logic [CEIL_W-1:0] ceil_v,
                               input logic [COEF_W-1:0] att_v,
                               input logic [COEF_W-1:0] rel_v);
            ceiling   = ceil_v;
            attack_c  = att_v;
            release_c = rel_v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the channel envelope and work out the limited sample
        function void note_request(input logic channel, input logic [SW-1:0] value);
            limiter_result_t r;
            logic            neg;
            longint          mag;
            longint          level;
            longint          coeff;
            longint          scaled;
            neg   = value[SW-1];
            mag   = neg ? (longint'(1) <<< SW) - longint'(value) : longint'(value);
            level = longint'(envelope[channel]);
            coeff = (mag > level) ? longint'(attack_c) : longint'(release_c);
            level = (coeff * level + (65536 - coeff) * mag + 32768) >>> 16;
            envelope[channel] = SW'(level);

            r.channel  = channel;
            r.limiting = level > longint'(ceiling);
            if (r.limiting)
            begin
                scaled = (mag * longint'(ceiling)) / level;
                if (neg)
                    scaled = -scaled;
            end
            else
            begin
                scaled = neg ? -mag : mag;
            end
            // Clamp to the signed sample range
            if (scaled > SAMPLE_MAX)
                scaled = SAMPLE_MAX;
            if (scaled < SAMPLE_MIN)
                scaled = SAMPLE_MIN;
            r.value = SW'(scaled);
            expected_q.push_back(r);
        endfunction

        task report_mismatch(input string what);
            errors++;
            $display("mismatch at %0t ns: %s", $time, what);
        endtask

        // Compare one output against the oldest pending result
        task check_result(input logic channel, input logic [SW-1:0] value,
                          input logic limiting);
            limiter_result_t want;
            if (expected_q.size() == 0)
            begin
                report_mismatch($sformatf("result with no request pending: ch %0d value %06h",
                                          channel, value));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want.limiting)
                limited++;
            if (channel !== want.channel)
                report_mismatch($sformatf("result %0d channel %0d, want %0d",
                                          checked, channel, want.channel));
            if (value !== want.value)
                report_mismatch($sformatf("result %0d sample %06h, want %06h",
                                          checked, value, want.value));
            if (limiting !== want.limiting)
                report_mismatch($sformatf("result %0d limiting %0d, want %0d",
                                          checked, limiting, want.limiting));
        endtask
    endclass

    limiter_scoreboard board = new();

    bit quiet        = 1'b0;
    bit hold_request = 1'b0;
    int hold_left    = 0;
    int sent         = 0;
    int settings     = 1;

    envelope_peak_limiter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: random stalls, long hold-off on request, none while quiet
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= 22);
            end
        end
    end

    // Check every accepted output
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser[0], m_axis_tdata[SW-1:0], m_axis_tuser[1]);
    end

    // Stop the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Offer one sample, idling first at random, and hold it until accepted
    task automatic send_sample(input logic channel, input logic [SW-1:0] value);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 99) < 22)
            gap = $urandom_range(1, 80);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(value);
        s_axis_tuser  <= channel;
        do
            @(posedge clk);
        while (!s_axis_tready);
        board.note_request(channel, value);
        sent++;
    endtask

    // Wait until every pending result has come out
    task automatic wait_results_drained();
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    // Write all three registers; only call with the block idle
    task automatic write_regs(input logic [CEIL_W-1:0] ceil_v,
                              input logic [COEF_W-1:0] att_v,
                              input logic [COEF_W-1:0] rel_v);
        cfg_we    <= 1'b1;
        cfg_addr  <= elp_pkg::CFG_CEILING;
        cfg_wdata <= CFG_DATA_W'(ceil_v);
        @(posedge clk);
        cfg_addr  <= elp_pkg::CFG_ATTACK;
        cfg_wdata <= CFG_DATA_W'(att_v);
        @(posedge clk);
        cfg_addr  <= elp_pkg::CFG_RELEASE;
        cfg_wdata <= CFG_DATA_W'(rel_v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_regs(ceil_v, att_v, rel_v);
        settings++;
    endtask

    // Mostly loud material so the envelope climbs, with noise and extremes mixed in
    function automatic logic [SW-1:0] random_sample();
        int            pick;
        logic [SW-1:0] mag;
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            mag = SW'($urandom_range(6000000, 8388607));
            return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
        end
        if (pick < 65)
            return SW'($urandom());
        if (pick < 85)
        begin
            mag = SW'($urandom_range(0, 4096));
            return $urandom_range(0, 1) ? (~mag + 1'b1) : mag;
        end
        case ($urandom_range(0, 4))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return 24'h000001;
        endcase
    endfunction

    // Random burst; optionally trigger the output hold-off or a full drain midway
    task automatic run_random(input int count, input int hold_at, input int pause_at);
        for (int k = 0; k < count; k++)
        begin
            if (k == hold_at)
                hold_request = 1'b1;
            if (k == pause_at)
            begin
                s_axis_tvalid <= 1'b0;
                wait_results_drained();
            end
            send_sample(1'($urandom_range(0, 1)), random_sample());
        end
        s_axis_tvalid <= 1'b0;
        wait_results_drained();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= elp_pkg::CFG_CEILING;
        cfg_wdata     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: full-scale and sign extremes, alternating bit patterns
        send_sample(1'b0, 24'h000000);
        send_sample(1'b1, 24'h7FFFFF);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b1, 24'hFFFFFF);
        send_sample(1'b0, 24'h000001);
        send_sample(1'b1, 24'h000000);
        send_sample(1'b0, 24'h555555);
        send_sample(1'b1, 24'hAAAAAA);
        s_axis_tvalid <= 1'b0;
        wait_results_drained();

        // Zero ceiling with instant envelope: any nonzero level mutes the sample
        write_regs(24'd0, 16'd0, 16'd0);
        send_sample(1'b0, 24'h000000);
        send_sample(1'b0, 24'h000001);
        send_sample(1'b1, 24'hFFFFFF);
        send_sample(1'b0, 24'h7FFFFF);
        send_sample(1'b1, 24'h800000);
        send_sample(1'b1, 24'h000000);
        s_axis_tvalid <= 1'b0;
        wait_results_drained();

        // Ceiling above full scale, release frozen at its slowest
        write_regs(24'h800000, 16'd0, 16'hFFFF);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b1, 24'h7FFFFF);
        send_sample(1'b0, 24'h000010);
        send_sample(1'b1, 24'hFFFFF0);
        s_axis_tvalid <= 1'b0;
        wait_results_drained();

        // Half-scale ceiling, envelope follows the magnitude at once
        write_regs(24'h400000, 16'd0, 16'd0);
        send_sample(1'b0, 24'h800000);
        send_sample(1'b1, 24'h7FFFFF);
        send_sample(1'b0, 24'hC00000);
        send_sample(1'b1, 24'h200000);
        send_sample(1'b0, 24'h400001);
        s_axis_tvalid <= 1'b0;
        wait_results_drained();

        // Default smoothing under a low ceiling, drained halfway
        write_regs(24'd2000000, elp_pkg::ATTACK_RESET, elp_pkg::RELEASE_RESET);
        run_random(300, -1, 150);

        // Random settings with both sides streaming flat out
        quiet = 1'b1;
        write_regs(CEIL_W'($urandom_range(0, 8388608)), COEF_W'($urandom()),
                   COEF_W'($urandom()));
        run_random(300, -1, -1);
        quiet = 1'b0;

        // Slowest smoothing against the smallest nonzero ceiling
        write_regs(24'd1, 16'hFFFF, 16'hFFFF);
        run_random(150, -1, -1);

        // Fast attack; stall the output long enough to back up the input
        write_regs(24'd6000000, 16'd30000, 16'd60000);
        run_random(300, 100, 200);

        // Back to the reset ceiling with random smoothing
        write_regs(elp_pkg::CEILING_RESET, COEF_W'($urandom_range(0, 40000)),
                   COEF_W'($urandom()));
        run_random(300, -1, -1);

        repeat (SETTLE) @(posedge clk);
        if (board.pending() != 0)
            board.report_mismatch($sformatf("%0d results never arrived", board.pending()));
        $display("summary: %0d samples sent, %0d results checked, %0d of them limited",
                 sent, board.checked, board.limited);
        $display("summary: %0d register settings incl. zero and above-full-scale ceilings",
                 settings);
        if (board.errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
